>>> sv/drt_pkg.sv
package drt_pkg;

   // List geometry
   localparam int MAX_REGIONS = 128;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int FILL_W      = $clog2(MAX_REGIONS + 1);

   // Field widths
   localparam int COORD_W     = 16;
   localparam int FIELD_W     = 12;
   localparam int COUNT_W     = 8;
   localparam int ENTRY_IDX_W = 7;
   localparam int MODE_W      = 3;
   localparam int CSR_IDX_W   = 2;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_ADD_MAIN   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD_EXT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_INVALIDATE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_END_FRAME  = 3'd4;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_X   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_Y   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_ROW = 2'd2;

   localparam logic [FIELD_W-1:0] LIMIT_X_RST   = 12'd640;
   localparam logic [FIELD_W-1:0] LIMIT_Y_RST   = 12'd480;
   localparam logic [FIELD_W-1:0] SPLIT_ROW_RST = 12'd360;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SPLIT_LO
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [COORD_W-1:0] rect_left;
      logic signed [COORD_W-1:0] rect_top;
      logic signed [COORD_W-1:0] rect_right;
      logic signed [COORD_W-1:0] rect_bottom;
      logic                      list_select;
      logic [ENTRY_IDX_W-1:0]    entry_index;
      logic                      scrolling;
   } req_payload_type;

   typedef struct packed {
      logic               full_refresh;
      logic [COUNT_W-1:0] main_count;
      logic [COUNT_W-1:0] ext_count;
      logic               entry_valid;
      logic [FIELD_W-1:0] entry_x;
      logic [FIELD_W-1:0] entry_y;
      logic [FIELD_W-1:0] entry_w;
      logic [FIELD_W-1:0] entry_h;
      logic               entry_skip;
   } rsp_payload_type;

   typedef struct packed {
      logic [FIELD_W-1:0] x;
      logic [FIELD_W-1:0] y;
      logic [FIELD_W-1:0] w;
      logic [FIELD_W-1:0] h;
   } region_type;

   localparam int REGION_W = $bits(region_type);

   typedef struct packed {
      logic       keep;
      region_type region;
   } clip_type;

endpackage

>>> sv/dirty_region_tracker_unit.sv
// Dirty region tracker: two lists of screen rectangles awaiting redraw and a
// full-refresh flag.
// Request channel (req_*): one transfer carries a mode and its operands. Add
// modes clamp the rectangle to the screen and append it to the main or the
// extended list; an extended add straddling the split row is stored as two
// rectangles. Other modes invalidate all, read one entry back, or end the frame.
// Response channel (rsp_*): exactly one transfer per request, in order, with
// the flag and both counts after the step plus any read-back entry.
// Register port (csr_*): screen width, screen height and split row; write it
// only while no request is in flight.
// Sequence: a taken request is registered and run in ST_EXEC, and its response
// is registered when the step completes; a straddling extended add also passes
// through ST_SPLIT_LO, as it needs two writes to the extended list memory. The
// next request is taken only once the unit is back in ST_IDLE; both lists sit
// in single-port-write memories with a registered read.
// Stall: the response register holds while rsp_stall is high; a finished step
// waits for it to drain before updating state, and req_stall stays high.
// Reset: both counts clear, full refresh is set and the registers return to
// 640 x 480 with split row 360. List memories are not cleared: only entries
// below the counts are ever returned, so no clearing pass is needed.
module dirty_region_tracker_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  drt_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output drt_pkg::rsp_payload_type          rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [drt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [drt_pkg::FIELD_W-1:0]       csr_data
);
   import drt_pkg::*;

   localparam int SPL_W = COORD_W + 1;

   state_type          state_ff, state_in;
   req_payload_type    req_ff;
   logic [FILL_W-1:0]  main_fill_ff, main_fill_in;
   logic [FILL_W-1:0]  ext_fill_ff, ext_fill_in;
   logic               force_full_ff, force_full_in;
   logic [FIELD_W-1:0] limit_x_ff, limit_y_ff, split_row_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   logic               req_accept, csr_write, out_free;
   logic               split_add, step_go, finish, do_add, add_ext, list_full;
   logic [FILL_W-1:0]  cur_fill, rd_cnt;
   logic               wr_main, wr_ext, hit, skip;
   logic signed [SPL_W-1:0]   split_s, top_e, bottom_e;
   logic signed [COORD_W-1:0] split16, clip_top, clip_bottom;
   logic [FIELD_W:0]   rd_bottom;
   clip_type           clip;
   region_type         main_rd, ext_rd, rd_region;

   // Handshakes
   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = !reset;
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Split test on the unclamped rectangle
   always_comb begin
      split_s   = signed'({{(SPL_W-FIELD_W){1'b0}}, split_row_ff});
      split16   = signed'({{(COORD_W-FIELD_W){1'b0}}, split_row_ff});
      top_e     = signed'({req_ff.rect_top[COORD_W-1], req_ff.rect_top});
      bottom_e  = signed'({req_ff.rect_bottom[COORD_W-1], req_ff.rect_bottom});
      split_add = (req_ff.mode == MODE_ADD_EXT) && (top_e <= split_s) &&
                  (bottom_e > split_s);
   end

   // Upper part first (bottom at the split row), then the lower part
   assign clip_top    = (state_ff == ST_SPLIT_LO) ? split16 : req_ff.rect_top;
   assign clip_bottom = ((state_ff == ST_EXEC) && split_add) ? split16
                                                            : req_ff.rect_bottom;

   drt_rect_clip u_clip (
      .rect_left   (req_ff.rect_left),
      .rect_top    (clip_top),
      .rect_right  (req_ff.rect_right),
      .rect_bottom (clip_bottom),
      .limit_x     (limit_x_ff),
      .limit_y     (limit_y_ff),
      .clip        (clip)
   );

   drt_region_ram #(.DEPTH(MAX_REGIONS), .DATA_W(REGION_W)) u_main_ram (
      .clock   (clock),
      .wr_en   (wr_main),
      .wr_addr (cur_fill[IDX_W-1:0]),
      .wr_data (clip.region),
      .rd_en   (req_accept),
      .rd_addr (IDX_W'(req_payload.entry_index)),
      .rd_data (main_rd)
   );

   drt_region_ram #(.DEPTH(MAX_REGIONS), .DATA_W(REGION_W)) u_ext_ram (
      .clock   (clock),
      .wr_en   (wr_ext),
      .wr_addr (cur_fill[IDX_W-1:0]),
      .wr_data (clip.region),
      .rd_en   (req_accept),
      .rd_addr (IDX_W'(req_payload.entry_index)),
      .rd_data (ext_rd)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (split_add)     state_in = ST_SPLIT_LO;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_SPLIT_LO: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Step datapath: list updates, read-back and response
   always_comb begin
      step_go   = ((state_ff == ST_EXEC) && (split_add || out_free)) ||
                  ((state_ff == ST_SPLIT_LO) && out_free);
      finish    = step_go && !((state_ff == ST_EXEC) && split_add);
      add_ext   = (req_ff.mode == MODE_ADD_EXT);
      do_add    = step_go && (add_ext ||
                  ((req_ff.mode == MODE_ADD_MAIN) && !force_full_ff));
      cur_fill  = add_ext ? ext_fill_ff : main_fill_ff;
      list_full = (cur_fill >= FILL_W'(MAX_REGIONS));

      main_fill_in  = main_fill_ff;
      ext_fill_in   = ext_fill_ff;
      force_full_in = force_full_ff;
      wr_main       = 1'b0;
      wr_ext        = 1'b0;

      if (do_add) begin
         if (list_full) begin
            // overflow: drop everything, redraw the whole screen
            main_fill_in  = '0;
            ext_fill_in   = '0;
            force_full_in = 1'b1;
         end else if (clip.keep) begin
            if (add_ext) begin
               wr_ext      = 1'b1;
               ext_fill_in = ext_fill_ff + 1'b1;
            end else begin
               wr_main      = 1'b1;
               main_fill_in = main_fill_ff + 1'b1;
            end
         end
      end
      if (step_go && (req_ff.mode == MODE_INVALIDATE)) begin
         main_fill_in  = '0;
         ext_fill_in   = '0;
         force_full_in = 1'b1;
      end
      if (step_go && (req_ff.mode == MODE_END_FRAME)) begin
         main_fill_in  = '0;
         ext_fill_in   = '0;
         force_full_in = 1'b0;
      end

      // Read-back: the memories were read at the request transfer
      rd_region = req_ff.list_select ? ext_rd : main_rd;
      rd_cnt    = req_ff.list_select ? ext_fill_ff : main_fill_ff;
      hit       = (req_ff.mode == MODE_READ) &&
                  (32'(req_ff.entry_index) < 32'(rd_cnt)) &&
                  (32'(req_ff.entry_index) < MAX_REGIONS);
      rd_bottom = {1'b0, rd_region.y} + {1'b0, rd_region.h};
      skip      = hit && req_ff.list_select && req_ff.scrolling &&
                  (rd_region.y <= split_row_ff) &&
                  (rd_bottom <= {1'b0, split_row_ff});

      rsp_payload_in.full_refresh = force_full_in;
      rsp_payload_in.main_count   = COUNT_W'(main_fill_in);
      rsp_payload_in.ext_count    = COUNT_W'(ext_fill_in);
      rsp_payload_in.entry_valid  = hit;
      rsp_payload_in.entry_x      = hit ? rd_region.x : '0;
      rsp_payload_in.entry_y      = hit ? rd_region.y : '0;
      rsp_payload_in.entry_w      = hit ? rd_region.w : '0;
      rsp_payload_in.entry_h      = hit ? rd_region.h : '0;
      rsp_payload_in.entry_skip   = skip;

      rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         main_fill_ff  <= '0;
         ext_fill_ff   <= '0;
         force_full_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         main_fill_ff  <= main_fill_in;
         ext_fill_ff   <= ext_fill_in;
         force_full_ff <= force_full_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Registers; an index beyond the list is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_x_ff   <= LIMIT_X_RST;
         limit_y_ff   <= LIMIT_Y_RST;
         split_row_ff <= SPLIT_ROW_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LIMIT_X:   limit_x_ff   <= csr_data;
            CSR_LIMIT_Y:   limit_y_ff   <= csr_data;
            CSR_SPLIT_ROW: split_row_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Payload registers: hold the request, load the response on completion
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_payload;
      end
      if (finish) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

>>> sv/drt_region_ram.sv
module drt_region_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = $clog2(DEPTH),
   parameter int DATA_W = 48
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/drt_rect_clip.sv
module drt_rect_clip (
   input  logic signed [drt_pkg::COORD_W-1:0] rect_left,
   input  logic signed [drt_pkg::COORD_W-1:0] rect_top,
   input  logic signed [drt_pkg::COORD_W-1:0] rect_right,
   input  logic signed [drt_pkg::COORD_W-1:0] rect_bottom,
   input  logic        [drt_pkg::FIELD_W-1:0] limit_x,
   input  logic        [drt_pkg::FIELD_W-1:0] limit_y,
   output drt_pkg::clip_type                  clip
);
   import drt_pkg::*;

   localparam int EXT_W = COORD_W + 1;
   localparam int DIF_W = COORD_W + 2;

   logic signed [EXT_W-1:0] lim_w, lim_h;
   logic signed [EXT_W-1:0] left_c, top_c, right_c, bottom_c;
   logic signed [EXT_W-1:0] right_e, bottom_e;
   logic signed [DIF_W-1:0] width_s, height_s;

   always_comb begin
      lim_w    = signed'({{(EXT_W-FIELD_W){1'b0}}, limit_x});
      lim_h    = signed'({{(EXT_W-FIELD_W){1'b0}}, limit_y});
      right_e  = signed'({rect_right[COORD_W-1], rect_right});
      bottom_e = signed'({rect_bottom[COORD_W-1], rect_bottom});

      // clamp up to the screen origin
      left_c   = rect_left[COORD_W-1] ? '0 : signed'({1'b0, rect_left});
      top_c    = rect_top[COORD_W-1]  ? '0 : signed'({1'b0, rect_top});
      // clamp down to the screen size
      right_c  = (right_e > lim_w)  ? lim_w : right_e;
      bottom_c = (bottom_e > lim_h) ? lim_h : bottom_e;

      width_s  = signed'({right_c[EXT_W-1], right_c}) - signed'({left_c[EXT_W-1], left_c});
      height_s = signed'({bottom_c[EXT_W-1], bottom_c}) - signed'({top_c[EXT_W-1], top_c});

      clip.keep     = !width_s[DIF_W-1] && (width_s != '0) &&
                      !height_s[DIF_W-1] && (height_s != '0);
      clip.region.x = left_c[FIELD_W-1:0];
      clip.region.y = top_c[FIELD_W-1:0];
      clip.region.w = width_s[FIELD_W-1:0];
      clip.region.h = height_s[FIELD_W-1:0];
   end

endmodule

>>> sv/drt_checker.sv
module drt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input drt_pkg::rsp_payload_type          rsp_payload
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

   // one request at a time: the cycle after a transfer is always stalled
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // entry fields are zero unless an entry was read back
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.entry_valid |->
         rsp_payload.entry_x == '0 && rsp_payload.entry_y == '0 &&
         rsp_payload.entry_w == '0 && rsp_payload.entry_h == '0 &&
         !rsp_payload.entry_skip)
      else $error("entry fields set without a valid entry");

   // stored rectangles are never empty, and skip marks only valid entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.entry_valid |->
         rsp_payload.entry_w != '0 && rsp_payload.entry_h != '0)
      else $error("empty rectangle read back");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.entry_skip |-> rsp_payload.entry_valid)
      else $error("skip mark on an invalid entry");

endmodule

bind dirty_region_tracker_unit drt_checker u_drt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
